### src/rbbp_pkg.sv
// Shared types, constants and the quarter-wave sine table of the radar blip box plotter.
// Used by rbbp_ctrl, rbbp_dp and radar_blip_box_plotter; depends on nothing else.
package rbbp_pkg;

    // Default geometry, handed to the top level as parameter defaults
    localparam int BOX_HALF_DEF      = 4;
    localparam int ORIGIN_X_DEF      = 160;
    localparam int ORIGIN_Y_DEF      = 200;
    localparam int SCREEN_WIDTH_DEF  = 320;
    localparam int SCREEN_HEIGHT_DEF = 240;
    localparam int RANGE_SCALE_DEF   = 4;

    // Field widths
    localparam int ANGLE_W = 8;
    localparam int RANGE_W = 8;
    localparam int COLOR_W = 16;
    localparam int ADDR_W  = 32;

    localparam int S_TDATA_W = ANGLE_W + RANGE_W + COLOR_W;
    localparam int M_TDATA_W = ADDR_W + COLOR_W;

    // Signed screen coordinate: center up to 511 plus an offset up to 2040
    localparam int COORD_W  = 13;
    localparam int UCOORD_W = COORD_W - 1;

    // Q1.15 magnitudes, 1.0 held as 32768
    localparam int MAG_W     = 17;
    localparam int Q_FRAC    = 15;
    localparam int ROM_IDX_W = 7;
    localparam int RS_W      = 11;            // range times scale, up to 255 * 8
    localparam int PROD_W    = RS_W + MAG_W;

    localparam int ROW_SHIFT_MAX = 10;
    localparam int SHIFT_W       = 4;

    localparam logic [ANGLE_W-1:0]   ANGLE_MAX  = 8'd180;
    localparam logic [ANGLE_W-1:0]   ANGLE_QUAD = 8'd90;
    localparam logic [ROM_IDX_W-1:0] ROM_LAST   = 7'd90;

    // Configuration register indexes
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_BASE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HALF_RES   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BYTE_COLOR = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOOKUP,
        ST_MUL_X,
        ST_MUL_Y,
        ST_PLACE,
        ST_RUN
    } state_t;

    typedef struct packed {
        logic load_in;
        logic lookup;
        logic mul_x;
        logic mul_y;
        logic place;
        logic emit;
    } cmd_t;

    typedef struct packed {
        logic hit;
        logic out_free;
        logic at_last;
    } status_t;

    // round(32768 * sin(k deg)), k = 0..90
    localparam logic [MAG_W-1:0] SINE_ROM [0:90] = '{
        17'd0,     17'd572,   17'd1144,  17'd1715,  17'd2286,
        17'd2856,  17'd3425,  17'd3993,  17'd4560,  17'd5126,
        17'd5690,  17'd6252,  17'd6813,  17'd7371,  17'd7927,
        17'd8481,  17'd9032,  17'd9580,  17'd10126, 17'd10668,
        17'd11207, 17'd11743, 17'd12275, 17'd12803, 17'd13328,
        17'd13848, 17'd14365, 17'd14876, 17'd15384, 17'd15886,
        17'd16384, 17'd16877, 17'd17364, 17'd17847, 17'd18324,
        17'd18795, 17'd19261, 17'd19720, 17'd20174, 17'd20622,
        17'd21063, 17'd21498, 17'd21926, 17'd22348, 17'd22763,
        17'd23170, 17'd23571, 17'd23965, 17'd24351, 17'd24730,
        17'd25102, 17'd25466, 17'd25822, 17'd26170, 17'd26510,
        17'd26842, 17'd27166, 17'd27482, 17'd27789, 17'd28088,
        17'd28378, 17'd28660, 17'd28932, 17'd29197, 17'd29452,
        17'd29698, 17'd29935, 17'd30163, 17'd30382, 17'd30592,
        17'd30792, 17'd30983, 17'd31164, 17'd31336, 17'd31499,
        17'd31651, 17'd31795, 17'd31928, 17'd32052, 17'd32166,
        17'd32270, 17'd32365, 17'd32449, 17'd32524, 17'd32588,
        17'd32643, 17'd32688, 17'd32723, 17'd32748, 17'd32763,
        17'd32768
    };

    function automatic logic [MAG_W-1:0] sine_q15(input logic [ROM_IDX_W-1:0] k);
        logic [MAG_W-1:0] v;
        v = '0;
        if (k <= ROM_LAST) begin
            v = SINE_ROM[k];
        end
        return v;
    endfunction

endpackage

### src/radar_blip_box_plotter.sv
// Top level of the radar blip box plotter: ties the sequencer to the datapath.
// Depends on rbbp_pkg, rbbp_ctrl and rbbp_dp.
//
//   channel | direction | handshake                     | payload
//   --------+-----------+-------------------------------+------------------------------------
//   s_      | in        | s_tvalid / s_tready           | s_tdata: angle, range, color
//   m_      | out       | m_tvalid / m_tready           | m_tdata: address, color; m_tlast
//   cfg_    | in        | cfg_wr_en (no back-pressure)  | cfg_index, cfg_wdata
//
// An echo goes through accept, sine lookup, two passes through the shared offset multiplier,
// box placement, then N pixel beats (N up to 64), one beat per cycle unless m_tready stalls.
// An echo off screen or with a bearing above 180 leaves with no beats.
// Reset is synchronous, active low; it clears the sequencer, output valid and config.
// A stall on m_tready holds the raster walk; the next echo is taken while the final
// beat still waits in the output register.
module radar_blip_box_plotter #(
    parameter int BOX_HALF      = rbbp_pkg::BOX_HALF_DEF,
    parameter int ORIGIN_X      = rbbp_pkg::ORIGIN_X_DEF,
    parameter int ORIGIN_Y      = rbbp_pkg::ORIGIN_Y_DEF,
    parameter int SCREEN_WIDTH  = rbbp_pkg::SCREEN_WIDTH_DEF,
    parameter int SCREEN_HEIGHT = rbbp_pkg::SCREEN_HEIGHT_DEF,
    parameter int RANGE_SCALE   = rbbp_pkg::RANGE_SCALE_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [rbbp_pkg::S_TDATA_W-1:0]  s_tdata,   // angle_deg, range_units, blip_color
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [rbbp_pkg::M_TDATA_W-1:0]  m_tdata,   // pixel_address, write color
    output logic                            m_tlast,
    input  logic                            cfg_wr_en,
    input  logic [rbbp_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [rbbp_pkg::CFG_DATA_W-1:0] cfg_wdata
);

    rbbp_pkg::cmd_t    cmd;
    rbbp_pkg::status_t status;

    rbbp_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    rbbp_dp #(
        .BOX_HALF      (BOX_HALF),
        .ORIGIN_X      (ORIGIN_X),
        .ORIGIN_Y      (ORIGIN_Y),
        .SCREEN_WIDTH  (SCREEN_WIDTH),
        .SCREEN_HEIGHT (SCREEN_HEIGHT),
        .RANGE_SCALE   (RANGE_SCALE)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cmd       (cmd),
        .status    (status)
    );

    // an accepted echo blocks the input until its work is done
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input ready right after an accepted echo");

    // a beat that is not the last one means the echo is still being walked
    a_mid_beat_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tlast) |-> !s_tready)
        else $error("input ready while an echo is unfinished");

    // at most one datapath command per cycle
    a_one_cmd: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0(cmd))
        else $error("datapath commands overlap");

    // the final beat of an echo returns the sequencer to idle
    a_last_to_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.emit && status.at_last) |=> s_tready)
        else $error("sequencer not idle after the final beat");

endmodule

### src/rbbp_ctrl.sv
// Sequencer of the radar blip box plotter: walks one echo through lookup, the two
// offset multiplies, box placement and the pixel raster. Depends on rbbp_pkg.
module rbbp_ctrl (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  rbbp_pkg::status_t status,
    output rbbp_pkg::cmd_t    cmd
);

    rbbp_pkg::state_t state_reg;
    rbbp_pkg::state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= rbbp_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            rbbp_pkg::ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = rbbp_pkg::ST_LOOKUP;
                end
            end
            rbbp_pkg::ST_LOOKUP: state_next = rbbp_pkg::ST_MUL_X;
            rbbp_pkg::ST_MUL_X:  state_next = rbbp_pkg::ST_MUL_Y;
            rbbp_pkg::ST_MUL_Y:  state_next = rbbp_pkg::ST_PLACE;
            rbbp_pkg::ST_PLACE: begin
                // drop echoes that miss the screen or carry a bad bearing
                state_next = status.hit ? rbbp_pkg::ST_RUN : rbbp_pkg::ST_IDLE;
            end
            rbbp_pkg::ST_RUN: begin
                if (status.out_free && status.at_last) begin
                    state_next = rbbp_pkg::ST_IDLE;
                end
            end
            default: state_next = rbbp_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        cmd      = '0;
        s_tready = 1'b0;
        case (state_reg)
            rbbp_pkg::ST_IDLE: begin
                s_tready    = 1'b1;
                cmd.load_in = s_tvalid;
            end
            rbbp_pkg::ST_LOOKUP: cmd.lookup = 1'b1;
            rbbp_pkg::ST_MUL_X:  cmd.mul_x  = 1'b1;
            rbbp_pkg::ST_MUL_Y:  cmd.mul_y  = 1'b1;
            rbbp_pkg::ST_PLACE:  cmd.place  = 1'b1;
            rbbp_pkg::ST_RUN:    cmd.emit   = status.out_free;
            default: cmd = '0;
        endcase
    end

endmodule

### src/rbbp_dp.sv
// Datapath of the radar blip box plotter: config registers, sine lookup, shared
// offset multiplier, box clipping, raster counters and output register. Uses rbbp_pkg.
module rbbp_dp #(
    parameter int BOX_HALF      = rbbp_pkg::BOX_HALF_DEF,
    parameter int ORIGIN_X      = rbbp_pkg::ORIGIN_X_DEF,
    parameter int ORIGIN_Y      = rbbp_pkg::ORIGIN_Y_DEF,
    parameter int SCREEN_WIDTH  = rbbp_pkg::SCREEN_WIDTH_DEF,
    parameter int SCREEN_HEIGHT = rbbp_pkg::SCREEN_HEIGHT_DEF,
    parameter int RANGE_SCALE   = rbbp_pkg::RANGE_SCALE_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic [rbbp_pkg::S_TDATA_W-1:0]    s_tdata,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [rbbp_pkg::M_TDATA_W-1:0]    m_tdata,
    output logic                              m_tlast,
    input  logic                              cfg_wr_en,
    input  logic [rbbp_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [rbbp_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    input  rbbp_pkg::cmd_t                    cmd,
    output rbbp_pkg::status_t                 status
);

    localparam int CW  = rbbp_pkg::COORD_W;
    localparam int UW  = rbbp_pkg::UCOORD_W;
    localparam int AW  = rbbp_pkg::ADDR_W;
    localparam int MW  = rbbp_pkg::MAG_W;
    localparam int PW  = rbbp_pkg::PROD_W;

    localparam logic signed [CW-1:0] CX_S   = CW'(ORIGIN_X);
    localparam logic signed [CW-1:0] CY_S   = CW'(ORIGIN_Y);
    localparam logic signed [CW-1:0] W_S    = CW'(SCREEN_WIDTH);
    localparam logic signed [CW-1:0] H_S    = CW'(SCREEN_HEIGHT);
    localparam logic signed [CW-1:0] XMAX_S = CW'(SCREEN_WIDTH - 1);
    localparam logic signed [CW-1:0] YMAX_S = CW'(SCREEN_HEIGHT - 1);
    localparam logic signed [CW-1:0] BH_S   = CW'(BOX_HALF);
    localparam logic signed [CW-1:0] BHM1_S = CW'(BOX_HALF - 1);
    localparam logic [rbbp_pkg::RS_W-1:0] SCALE_U = rbbp_pkg::RS_W'(RANGE_SCALE);

    // configuration
    logic [AW-1:0] base_reg;
    logic          half_res_reg;
    logic          byte_col_reg;

    // echo payload
    logic [rbbp_pkg::ANGLE_W-1:0] angle_reg;
    logic [rbbp_pkg::RANGE_W-1:0] range_reg;
    logic [rbbp_pkg::COLOR_W-1:0] color_reg;

    logic [MW-1:0]        sin_mag_reg;
    logic [MW-1:0]        cos_mag_reg;
    logic                 cos_neg_reg;
    logic                 angle_ok_reg;
    logic signed [CW-1:0] x_reg;
    logic signed [CW-1:0] y_reg;

    logic [UW-1:0] c1_reg;
    logic [UW-1:0] c2_reg;
    logic [UW-1:0] r2_reg;
    logic [UW-1:0] row_reg;
    logic [UW-1:0] col_reg;

    logic [AW-1:0]                out_addr_reg;
    logic [rbbp_pkg::COLOR_W-1:0] out_color_reg;
    logic                         out_last_reg;
    logic                         out_valid_reg;

    // sine/cosine lookup
    logic                         in_lo;
    logic [rbbp_pkg::ANGLE_W-1:0] sin_idx;
    logic [rbbp_pkg::ANGLE_W-1:0] cos_idx;

    assign in_lo   = angle_reg <= rbbp_pkg::ANGLE_QUAD;
    assign sin_idx = in_lo ? angle_reg : rbbp_pkg::ANGLE_MAX - angle_reg;
    assign cos_idx = in_lo ? rbbp_pkg::ANGLE_QUAD - angle_reg
                           : angle_reg - rbbp_pkg::ANGLE_QUAD;

    // shared offset multiplier
    logic [rbbp_pkg::RS_W-1:0] range_scaled;
    logic [MW-1:0]             mag_sel;
    logic [PW-1:0]             prod;
    logic signed [CW-1:0]      off_s;

    assign range_scaled = rbbp_pkg::RS_W'(rbbp_pkg::RS_W'(range_reg) * SCALE_U);
    assign mag_sel      = cmd.mul_x ? cos_mag_reg : sin_mag_reg;
    assign prod         = PW'(range_scaled) * PW'(mag_sel);
    assign off_s        = signed'({1'b0, prod[rbbp_pkg::Q_FRAC +: UW]});

    // box placement and clipping
    logic                 on_screen;
    logic signed [CW-1:0] x_lo, x_hi, y_lo, y_hi;
    logic signed [CW-1:0] x_lo_c, x_hi_c, y_lo_c, y_hi_c;
    logic [1:0]           xs;
    logic                 ys;
    logic [rbbp_pkg::SHIFT_W-1:0] stride;

    assign on_screen = (x_reg >= 0) && (x_reg < W_S) && (y_reg >= 0) && (y_reg < H_S);
    assign x_lo   = x_reg - BH_S;
    assign x_hi   = x_reg + BHM1_S;
    assign y_lo   = y_reg - BH_S;
    assign y_hi   = y_reg + BHM1_S;
    assign x_lo_c = (x_lo < 0) ? '0 : x_lo;
    assign y_lo_c = (y_lo < 0) ? '0 : y_lo;
    assign x_hi_c = (x_hi > XMAX_S) ? XMAX_S : x_hi;
    assign y_hi_c = (y_hi > YMAX_S) ? YMAX_S : y_hi;
    assign xs     = {1'b0, half_res_reg} + {1'b0, byte_col_reg};
    assign ys     = half_res_reg;
    assign stride = rbbp_pkg::SHIFT_W'(rbbp_pkg::ROW_SHIFT_MAX) - {2'b00, xs};

    logic [AW-1:0] pix_addr;
    assign pix_addr = base_reg + (AW'(row_reg) << stride) + (AW'(col_reg) << 1);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            base_reg     <= '0;
            half_res_reg <= 1'b0;
            byte_col_reg <= 1'b0;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                rbbp_pkg::CFG_FRAME_BASE: base_reg     <= cfg_wdata;
                rbbp_pkg::CFG_HALF_RES:   half_res_reg <= cfg_wdata[0];
                rbbp_pkg::CFG_BYTE_COLOR: byte_col_reg <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            angle_reg <= s_tdata[rbbp_pkg::ANGLE_W-1:0];
            range_reg <= s_tdata[rbbp_pkg::ANGLE_W +: rbbp_pkg::RANGE_W];
            color_reg <= s_tdata[rbbp_pkg::ANGLE_W + rbbp_pkg::RANGE_W +: rbbp_pkg::COLOR_W];
        end
        if (cmd.lookup) begin
            sin_mag_reg  <= rbbp_pkg::sine_q15(sin_idx[rbbp_pkg::ROM_IDX_W-1:0]);
            cos_mag_reg  <= rbbp_pkg::sine_q15(cos_idx[rbbp_pkg::ROM_IDX_W-1:0]);
            cos_neg_reg  <= !in_lo;
            angle_ok_reg <= angle_reg <= rbbp_pkg::ANGLE_MAX;
        end
        if (cmd.mul_x) begin
            x_reg <= cos_neg_reg ? CX_S - off_s : CX_S + off_s;
        end
        if (cmd.mul_y) begin
            y_reg <= CY_S - off_s;
        end
        if (cmd.place) begin
            c1_reg  <= x_lo_c[UW-1:0] >> xs;
            c2_reg  <= x_hi_c[UW-1:0] >> xs;
            r2_reg  <= y_hi_c[UW-1:0] >> ys;
            row_reg <= y_lo_c[UW-1:0] >> ys;
            col_reg <= x_lo_c[UW-1:0] >> xs;
        end else if (cmd.emit) begin
            // advance column, wrap to the next row at the right edge
            if (col_reg == c2_reg) begin
                col_reg <= c1_reg;
                row_reg <= row_reg + 1'b1;
            end else begin
                col_reg <= col_reg + 1'b1;
            end
        end
        if (cmd.emit) begin
            out_addr_reg  <= pix_addr;
            out_color_reg <= color_reg;
            out_last_reg  <= status.at_last;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.emit) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    assign status.hit      = angle_ok_reg && on_screen;
    assign status.out_free = !out_valid_reg || m_tready;
    assign status.at_last  = (row_reg == r2_reg) && (col_reg == c2_reg);

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_color_reg, out_addr_reg};
    assign m_tlast  = out_last_reg;

endmodule

### verif/tb_radar_blip_box_plotter.sv
`timescale 1ns / 1ps
// Self-checking testbench for radar_blip_box_plotter: drives echoes and config writes,
// predicts every pixel write and checks the m_ beats in order. Depends on rbbp_pkg and the DUT.
module tb_radar_blip_box_plotter;

    // Screen geometry of the default build
    localparam int BOX = 4;
    localparam int ORIGIN_X = 160;
    localparam int ORIGIN_Y = 200;
    localparam int SCR_W = 320;
    localparam int SCR_H = 240;
    localparam int DIST_GAIN = 4;
    localparam int ECHOES_PER_PHASE = 67;
    localparam int SETTLE_CYCLES = 20;

    localparam int AW  = rbbp_pkg::ADDR_W;
    localparam int CLW = rbbp_pkg::COLOR_W;
    localparam int ANW = rbbp_pkg::ANGLE_W;
    localparam int RGW = rbbp_pkg::RANGE_W;

    // Idle schemes
    localparam int IDLE_NONE = 0;
    localparam int IDLE_SENDER = 1;
    localparam int IDLE_RECEIVER = 2;
    localparam int IDLE_BOTH = 3;

    // round(32768 * sin(k deg)), k = 0..90
    localparam int unsigned SIN_Q15 [0:90] = '{
            0,   572,  1144,  1715,  2286,  2856,  3425,  3993,  4560,  5126,
         5690,  6252,  6813,  7371,  7927,  8481,  9032,  9580, 10126, 10668,
        11207, 11743, 12275, 12803, 13328, 13848, 14365, 14876, 15384, 15886,
        16384, 16877, 17364, 17847, 18324, 18795, 19261, 19720, 20174, 20622,
        21063, 21498, 21926, 22348, 22763, 23170, 23571, 23965, 24351, 24730,
        25102, 25466, 25822, 26170, 26510, 26842, 27166, 27482, 27789, 28088,
        28378, 28660, 28932, 29197, 29452, 29698, 29935, 30163, 30382, 30592,
        30792, 30983, 31164, 31336, 31499, 31651, 31795, 31928, 32052, 32166,
        32270, 32365, 32449, 32524, 32588, 32643, 32688, 32723, 32748, 32763,
        32768
    };

    typedef struct {
        logic [AW-1:0]  addr;
        logic [CLW-1:0] color;
        logic           last;
    } pixel_write_t;

    class echo_scoreboard;
        pixel_write_t  pending_writes[$];
        logic [AW-1:0] frame_base;
        bit            half_res;
        bit            byte_color;
        int unsigned   errors;

        function new();
            frame_base = '0;
            half_res   = 1'b0;
            byte_color = 1'b0;
            errors     = 0;
        endfunction

        function void set_config(logic [AW-1:0] base, bit res, bit col);
            frame_base = base;
            half_res   = res;
            byte_color = col;
        endfunction

        task report_mismatch(string msg);
            $display("MISMATCH @%0t: %s", $realtime, msg);
            errors++;
        endtask

        // Work out the pixel writes of one accepted echo and queue them
        function void note_echo(logic [ANW-1:0] bearing, logic [RGW-1:0] range_val,
                                logic [CLW-1:0] color);
            int unsigned  sin_q, cos_q, step_x, step_y, xs, ys;
            int unsigned  col_lo, col_hi, row_lo, row_hi, r, c;
            int           px, py, x_lo, x_hi, y_lo, y_hi;
            bit           west;
            pixel_write_t w;
            if (bearing > 8'd180) return;
            if (bearing <= 8'd90) begin
                sin_q = SIN_Q15[bearing];
                cos_q = SIN_Q15[90 - bearing];
                west  = 1'b0;
            end else begin
                sin_q = SIN_Q15[180 - bearing];
                cos_q = SIN_Q15[bearing - 90];
                west  = 1'b1;
            end
            step_x = (int'(range_val) * DIST_GAIN * cos_q) >> 15;
            step_y = (int'(range_val) * DIST_GAIN * sin_q) >> 15;
            px = west ? ORIGIN_X - int'(step_x) : ORIGIN_X + int'(step_x);
            py = ORIGIN_Y - int'(step_y);
            if (px < 0 || px >= SCR_W || py < 0 || py >= SCR_H) return;
            // clip the box to the screen
            x_lo = (px - BOX < 0) ? 0 : px - BOX;
            y_lo = (py - BOX < 0) ? 0 : py - BOX;
            x_hi = (px + BOX - 1 > SCR_W - 1) ? SCR_W - 1 : px + BOX - 1;
            y_hi = (py + BOX - 1 > SCR_H - 1) ? SCR_H - 1 : py + BOX - 1;
            xs = half_res + byte_color;
            ys = half_res;
            col_lo = x_lo >> xs;
            col_hi = x_hi >> xs;
            row_lo = y_lo >> ys;
            row_hi = y_hi >> ys;
            for (r = row_lo; r <= row_hi; r++) begin
                for (c = col_lo; c <= col_hi; c++) begin
                    w.addr  = frame_base + (r << (10 - xs)) + (c << 1);
                    w.color = color;
                    w.last  = (r == row_hi && c == col_hi);
                    pending_writes.push_back(w);
                end
            end
        endfunction

        task check_beat(logic [AW-1:0] addr, logic [CLW-1:0] color, logic last);
            pixel_write_t w;
            if (pending_writes.size() == 0) begin
                report_mismatch($sformatf("unexpected beat addr=%h color=%h last=%b",
                                          addr, color, last));
                return;
            end
            w = pending_writes.pop_front();
            if (addr !== w.addr)
                report_mismatch($sformatf("addr %h, want %h", addr, w.addr));
            if (color !== w.color)
                report_mismatch($sformatf("color %h, want %h", color, w.color));
            if (last !== w.last)
                report_mismatch($sformatf("tlast %b, want %b (addr %h)", last, w.last, w.addr));
        endtask
    endclass

    logic                            aclk;
    logic                            aresetn;
    logic                            s_tvalid;
    logic                            s_tready;
    logic [rbbp_pkg::S_TDATA_W-1:0]  s_tdata;    // angle_deg, range_units, blip_color
    logic                            m_tvalid;
    logic                            m_tready;
    logic [rbbp_pkg::M_TDATA_W-1:0]  m_tdata;    // pixel_address, write color
    logic                            m_tlast;
    logic                            cfg_wr_en;
    logic [rbbp_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [rbbp_pkg::CFG_DATA_W-1:0] cfg_wdata;

    echo_scoreboard sb;
    int             idle_mode;

    radar_blip_box_plotter dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    initial aclk = 1'b0;
    always #1 aclk = ~aclk;

    function automatic bit chance(int pct);
        return $urandom_range(99) < pct;
    endfunction

    // Receiver back-pressure
    always @(negedge aclk) begin
        case (idle_mode)
            IDLE_RECEIVER: m_tready <= !chance(73);
            IDLE_BOTH:     m_tready <= !chance(32);
            default:       m_tready <= 1'b1;
        endcase
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            sb.check_beat(m_tdata[AW-1:0], m_tdata[AW +: CLW], m_tlast);
    end

    task automatic send_echo(logic [ANW-1:0] bearing, logic [RGW-1:0] range_val,
                             logic [CLW-1:0] color);
        int gap_pct;
        gap_pct = (idle_mode == IDLE_SENDER) ? 73 : (idle_mode == IDLE_BOTH) ? 32 : 0;
        @(negedge aclk);
        while (chance(gap_pct)) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {color, range_val, bearing};
        do @(posedge aclk); while (!s_tready);
        sb.note_echo(bearing, range_val, color);
    endtask

    // Drop valid and let every expected write drain plus any silent echo finish
    task automatic wait_drained();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (sb.pending_writes.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic program_display(logic [AW-1:0] base, bit res, bit col);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= rbbp_pkg::CFG_FRAME_BASE;
        cfg_wdata <= base;
        @(negedge aclk);
        cfg_index <= rbbp_pkg::CFG_HALF_RES;
        cfg_wdata <= {31'b0, res};
        @(negedge aclk);
        cfg_index <= rbbp_pkg::CFG_BYTE_COLOR;
        cfg_wdata <= {31'b0, col};
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        sb.set_config(base, res, col);
    endtask

    task automatic run_directed();
        send_echo(8'd0,   8'd0,   16'h0000);    // box around the origin
        send_echo(8'd90,  8'd50,  16'hFFFF);    // top edge, clipped rows
        send_echo(8'd89,  8'd50,  16'h8001);
        send_echo(8'd180, 8'd40,  16'h1234);    // left edge, clipped columns
        send_echo(8'd179, 8'd40,  16'h4321);
        send_echo(8'd1,   8'd40,  16'h7FFE);    // right edge
        send_echo(8'd0,   8'd40,  16'hC3C3);    // just past the right edge
        send_echo(8'd90,  8'd51,  16'h3C3C);    // just above the top
        send_echo(8'd0,   8'd255, 16'hFFFF);
        send_echo(8'd180, 8'd255, 16'h0001);
        send_echo(8'd90,  8'd255, 16'hAAAA);
        send_echo(8'd181, 8'd10,  16'h5555);    // bearing out of range
        send_echo(8'd255, 8'd255, 16'hFFFF);
        send_echo(8'd45,  8'd30,  16'hA5A5);
        send_echo(8'd135, 8'd30,  16'h5A5A);
        send_echo(8'd90,  8'd0,   16'h0F0F);
        send_echo(8'd128, 8'd20,  16'hF0F0);
        send_echo(8'd60,  8'd45,  16'h00FF);
        send_echo(8'd120, 8'd45,  16'hFF00);
        send_echo(8'd170, 8'd38,  16'h2468);
    endtask

    // Mostly on-screen echoes; some near the edges, some anywhere, some ignored
    task automatic run_random(int n_echoes);
        int             sent;
        int             pick;
        logic [ANW-1:0] bearing;
        logic [RGW-1:0] range_val;
        sent = 0;
        while (sent < n_echoes) begin
            pick = $urandom_range(99);
            if (pick < 65) begin
                bearing   = ANW'($urandom_range(180));
                range_val = RGW'($urandom_range(50));
            end else if (pick < 80) begin
                case ($urandom_range(3))
                    0: bearing = ANW'($urandom_range(3));
                    1: bearing = ANW'(180 - $urandom_range(3));
                    2: bearing = ANW'(90 + $urandom_range(6) - 3);
                    default: bearing = ANW'($urandom_range(180));
                endcase
                range_val = RGW'(36 + $urandom_range(16));
            end else if (pick < 92) begin
                bearing   = ANW'($urandom_range(180));
                range_val = RGW'($urandom_range(255));
            end else begin
                bearing   = ANW'($urandom_range(255, 181));
                range_val = RGW'($urandom_range(255));
            end
            send_echo(bearing, range_val, CLW'($urandom_range(16'hFFFF)));
            sent++;
        end
    endtask

    initial begin
        int phase;
        sb        = new();
        idle_mode = IDLE_NONE;
        aresetn   = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        cfg_wr_en = 1'b0;
        cfg_index = rbbp_pkg::CFG_FRAME_BASE;
        cfg_wdata = '0;
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        for (phase = 0; phase < 6; phase++) begin
            idle_mode = phase % 4;
            case (phase)
                0: ;    // reset values
                1: begin wait_drained(); program_display(32'hFFFF_FFF0, 1'b1, 1'b0); end
                2: begin wait_drained(); program_display($urandom, 1'b0, 1'b1); end
                3: begin wait_drained(); program_display(32'hFFFF_FFFF, 1'b1, 1'b1); end
                4: begin wait_drained(); program_display(32'h0000_0000, 1'b0, 1'b0); end
                default: begin
                    wait_drained();
                    program_display($urandom, 1'($urandom_range(1)), 1'($urandom_range(1)));
                end
            endcase
            if (phase == 0) run_directed();
            run_random(ECHOES_PER_PHASE);
        end
        wait_drained();
        repeat (80) @(posedge aclk);

        if (sb.errors == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("FAILED: results differ");
        $finish;
    end

endmodule

### files.f
src/rbbp_pkg.sv
src/rbbp_ctrl.sv
src/rbbp_dp.sv
src/radar_blip_box_plotter.sv
verif/tb_radar_blip_box_plotter.sv
